// ----- rtl/core/hutf_pkg.sv -----
package hutf_pkg;

  localparam logic [1:0] LANG_ENGLISH  = 2'd1;
  localparam logic [1:0] LANG_MANDARIN = 2'd2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_TERM  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LANGUAGE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEX_UNICODE_MODE = 2'd1;

  localparam logic [15:0] CJK_FIRST   = 16'h4E00;
  localparam logic [7:0]  ASCII_0     = 8'h30;
  localparam logic [7:0]  ASCII_9     = 8'h39;
  localparam logic [7:0]  ASCII_UA    = 8'h41;
  localparam logic [7:0]  ASCII_UZ    = 8'h5A;
  localparam logic [7:0]  ASCII_LA    = 8'h61;
  localparam logic [7:0]  ASCII_LZ    = 8'h7A;
  localparam logic [7:0]  ALPHA_BIAS  = 8'h37;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;

  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = 2;
  localparam int RES_CNT_W = 3;
  localparam int QDEPTH    = 4;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_name;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      count;
    logic [MAX_RES-1:0][7:0]   data_b;
    logic [MAX_RES-1:0][1:0]   kind_b;
  } cmd_t;

endpackage

// ----- rtl/core/hutf_front.sv -----
module hutf_front #(
  parameter int TEXT_BYTES = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hutf_pkg::in_word_t in_word,
  input  logic [1:0]         language_mode,
  input  logic               hex_unicode_mode,
  input  logic               q_full,
  output logic               q_push,
  output hutf_pkg::cmd_t     q_cmd
);

  localparam int CNT_W = $clog2(TEXT_BYTES);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(TEXT_BYTES - 1);

  logic [15:0]      acc_r, acc_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             abort_r, abort_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic [5:0]       dval;
  logic [15:0]      acc_or;
  logic [2:0][7:0]  wb;
  logic [1:0]       wn;
  logic             ab;
  logic [CNT_W-1:0] avail;
  logic [1:0]       m;
  logic             term;
  logic             last;
  logic [7:0]       c;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_word.in_char;
  assign last     = in_word.end_of_name;

  always_comb begin
    if (c >= hutf_pkg::ASCII_0 && c <= hutf_pkg::ASCII_9) begin
      dval = 6'(c - hutf_pkg::ASCII_0);
    end else if (c >= hutf_pkg::ASCII_UA && c <= hutf_pkg::ASCII_UZ) begin
      dval = 6'(c - hutf_pkg::ALPHA_BIAS);
    end else begin
      dval = 6'd0;
    end
    acc_or = acc_r | ({10'b0, dval} << {~pos_r, 2'b00});
  end

  always_comb begin
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    abort_nxt = abort_r;
    wb        = '0;
    wn        = 2'd0;
    ab        = 1'b0;
    if (!abort_r) begin
      if (hex_unicode_mode) begin
        if (pos_r == 2'd3) begin
          acc_nxt = '0;
          pos_nxt = 2'd0;
          if (acc_or >= hutf_pkg::CJK_FIRST) begin
            if (language_mode == hutf_pkg::LANG_ENGLISH) begin
              ab = 1'b1;
            end else begin
              wn    = 2'd3;
              wb[0] = hutf_pkg::UTF8_LEAD3 | {4'b0, acc_or[15:12]};
              wb[1] = hutf_pkg::UTF8_CONT | {2'b0, acc_or[11:6]};
              wb[2] = hutf_pkg::UTF8_CONT | {2'b0, acc_or[5:0]};
            end
          end else if ((acc_or >= {8'h00, hutf_pkg::ASCII_UA} &&
                        acc_or <= {8'h00, hutf_pkg::ASCII_UZ}) ||
                       (acc_or >= {8'h00, hutf_pkg::ASCII_LA} &&
                        acc_or <= {8'h00, hutf_pkg::ASCII_LZ})) begin
            if (language_mode == hutf_pkg::LANG_MANDARIN) begin
              ab = 1'b1;
            end else begin
              wn    = 2'd1;
              wb[0] = acc_or[7:0];
            end
          end
        end else begin
          acc_nxt = acc_or;
          pos_nxt = pos_r + 2'd1;
        end
      end else begin
        wn    = 2'd1;
        wb[0] = c;
      end
      abort_nxt = ab;
    end
    avail = CAP - cnt_r;
    m     = (CNT_W'(wn) > avail) ? 2'(avail) : wn;
    term  = last && !abort_r && !ab;
    cnt_nxt = cnt_r + CNT_W'(m);
    if (last) begin
      acc_nxt   = '0;
      pos_nxt   = 2'd0;
      abort_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    q_cmd = '0;
    if (ab) begin
      q_cmd.count     = 3'd1;
      q_cmd.kind_b[0] = hutf_pkg::KIND_ABORT;
    end else begin
      q_cmd.count = {1'b0, m} + {2'b0, term};
      for (int i = 0; i < hutf_pkg::MAX_RES; i++) begin
        if (i < int'(m)) begin
          q_cmd.kind_b[i] = hutf_pkg::KIND_DATA;
          if (i < 3) begin
            q_cmd.data_b[i] = wb[i];
          end
        end else if (i == int'(m)) begin
          q_cmd.kind_b[i] = hutf_pkg::KIND_TERM;
        end
      end
    end
  end

  assign q_push = accept && (q_cmd.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pos_r   <= '0;
      abort_r <= 1'b0;
      cnt_r   <= '0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      abort_r <= abort_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP)
    else $error("byte count past cap");

  a_abort_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && abort_r |-> !q_push)
    else $error("word pushed for aborted name");

  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    abort_r |-> acc_r == '0 && pos_r == 2'd0)
    else $error("hex group left over after abort");

endmodule

// ----- rtl/core/hutf_queue.sv -----
module hutf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hutf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output hutf_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(hutf_pkg::QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  hutf_pkg::cmd_t   mem_r [hutf_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(hutf_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/hutf_back.sv -----
module hutf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  hutf_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hutf_pkg::out_word_t out_word
);

  logic [hutf_pkg::RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                           valid_r, valid_nxt;
  hutf_pkg::out_word_t            word_r, word_nxt;
  logic                           load;
  logic                           at_last;

  assign load    = !valid_r || !out_stall;
  assign at_last = ({1'b0, idx_r} == q_head.count - 3'd1);

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    word_nxt  = word_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        word_nxt.out_byte    = q_head.data_b[idx_r];
        word_nxt.out_kind    = q_head.kind_b[idx_r];
        word_nxt.last_of_run = at_last;
        q_pop                = at_last;
        idx_nxt              = at_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> {1'b0, idx_r} < q_head.count)
    else $error("result index past run length");

endmodule

// ----- rtl/core/hex_ucs2_to_utf8_text_filter.sv -----
// Caller-name text filter: in hex mode four upper-case hex characters form one
// 16-bit code unit, sent on as three UTF-8 bytes (unit 0x4E00 and up) or one
// ASCII letter byte, other units dropped; a language mismatch gives a single
// abort word and silences the rest of the name. Pass-through mode copies bytes.
// A terminator word follows the last byte of a name unless it was aborted, and
// at most TEXT_BYTES-1 data bytes leave per name. The front stage takes one
// input word per clock while the queue is not full; results wait in a 4-entry
// queue and the back stage sends one result word per clock unless out_stall
// is high, and in_stall rises only when the queue is full. Each result passes
// through the queue and the back output register. cfg_ready is always high;
// write configuration only while the block is idle.
module hex_ucs2_to_utf8_text_filter #(
  parameter int TEXT_BYTES = 50
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hutf_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hutf_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hutf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hutf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [1:0]     lang_r;
  logic           hexm_r;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  hutf_pkg::cmd_t q_cmd;
  hutf_pkg::cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lang_r <= 2'd0;
      hexm_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hutf_pkg::REG_LANGUAGE_MODE: begin
          lang_r <= cfg_data[1:0];
        end
        hutf_pkg::REG_HEX_UNICODE_MODE: begin
          hexm_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  hutf_front #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_word          (in_word),
    .language_mode    (lang_r),
    .hex_unicode_mode (hexm_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  hutf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  hutf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
